### hdl/tpbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_pkg
// Types, constants and the Hamming 8/4 decoder for the PFC block demultiplexer.
// ----------------------------------------------------------------------------
package tpbd_pkg;

    localparam logic [3:0]  SEPARATOR  = 4'hC;
    localparam logic [3:0]  FILLER     = 4'h3;
    localparam logic [4:0]  NO_CI      = 5'd16;
    localparam logic [4:0]  NO_PKT     = 5'd31;
    localparam logic [4:0]  MAX_PACKET = 5'd25;
    localparam logic [5:0]  MAX_BP     = 6'd39;
    localparam logic [5:0]  LAST_POS   = 6'd41;
    localparam logic [11:0] MAG8_CODE  = 12'h800;

    localparam logic CFG_PAGE   = 1'b0;
    localparam logic CFG_STREAM = 1'b1;

    typedef enum logic [2:0] {
        PH_IGNORE = 3'd0,
        PH_ADDR   = 3'd1,
        PH_HEADER = 3'd2,
        PH_BP     = 3'd3,
        PH_SEEK   = 3'd4,
        PH_COPY   = 3'd5,
        PH_SCAN   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_EMPTY = 2'd1,
        K_RESET = 2'd2,
        K_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [5:0] byte_pos;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [10:0] block_offset;
        logic [4:0]  app_code;
        logic [10:0] block_len;
        logic        last_of_block;
    } t_out;

    typedef struct packed {
        logic [4:0]  exp_ci;
        logic [4:0]  exp_pkt;
        logic [4:0]  pkts;
        logic [10:0] bytes_left;
        logic [10:0] block_index;
        logic        reading_header;
        logic [15:0] header_bits;
        logic        header_bad;
        logic [4:0]  app_id;
        logic [10:0] size;
        logic [31:0] prefix;
        t_phase      phase;
        logic [5:0]  block_ptr;
        logic [5:0]  next_pos;
    } t_state;

    localparam logic [7:0] HAM_CODE [16] = '{
        8'h15, 8'h02, 8'h49, 8'h5E, 8'h64, 8'h73, 8'h38, 8'h2F,
        8'hD0, 8'hC7, 8'h8C, 8'h9B, 8'hA1, 8'hB6, 8'hFD, 8'hEA
    };

    // {ok, nibble}; the lowest-index matching code wins
    function automatic logic [4:0] ham_decode(input logic [7:0] b);
        logic [4:0] r;
        logic [7:0] x;
        r = 5'd0;
        for (int d = 15; d >= 0; d--) begin
            x = b ^ HAM_CODE[d];
            if ((x & (x - 8'd1)) == 8'd0) begin
                r = {1'b1, 4'(d)};
            end
        end
        return r;
    endfunction

endpackage

### hdl/tpbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_step
// Next-state and result logic for one packet byte.
// ----------------------------------------------------------------------------
module tpbd_step (
    input  tpbd_pkg::t_state i_state,
    input  tpbd_pkg::t_in    i_item,
    input  logic [11:0]      i_page,
    input  logic [3:0]       i_stream,
    output tpbd_pkg::t_state o_state,
    output logic             o_res_valid,
    output tpbd_pkg::t_out   o_res
);
    import tpbd_pkg::*;

    logic [4:0]  ham;
    logic        ok;
    logic [3:0]  nib;
    logic [5:0]  pos;
    logic [31:0] pfx;
    logic [11:0] mag;
    logic [4:0]  packet;
    logic [15:0] hb;
    logic        hdr_sync;
    t_state      s;

    always_comb begin
        ham = ham_decode(i_item.byte_value);
        ok  = ham[4];
        nib = ham[3:0];
        pos = i_item.byte_pos;
        s   = i_state;
        o_res_valid = 1'b0;
        o_res = '0;
        pfx = '0;
        mag = '0;
        packet = '0;
        hb = '0;
        hdr_sync = 1'b0;

        if (pos == 6'd0) begin
            s.next_pos = 6'd1;
            s.phase = PH_ADDR;
            s.prefix = {28'd0, nib};
            if (!ok) begin
                o_res_valid = 1'b1;
                o_res.kind = K_ERROR;
            end
        end else if (pos != i_state.next_pos || pos > LAST_POS) begin
            s.phase = PH_IGNORE;
        end else begin
            s.next_pos = pos + 6'd1;
            case (i_state.phase)
                PH_ADDR: begin
                    pfx = i_state.prefix | {24'd0, nib, 4'd0};
                    mag = (pfx[2:0] == 3'd0) ? MAG8_CODE : {1'b0, pfx[2:0], 8'd0};
                    packet = {nib, pfx[3]};
                    s.prefix = pfx;
                    if (!ok) begin
                        o_res_valid = 1'b1;
                        o_res.kind = K_ERROR;
                    end else if (packet == 5'd0) begin
                        s.phase = PH_HEADER;
                    end else if (mag[11:8] != i_page[11:8] || i_state.pkts == 5'd0 ||
                                 packet > MAX_PACKET) begin
                        s.phase = PH_IGNORE;
                    end else if (packet != i_state.exp_pkt || packet > i_state.pkts) begin
                        o_res_valid = 1'b1;
                        o_res.kind = K_RESET;
                    end else begin
                        s.exp_pkt = packet + 5'd1;
                        s.phase = PH_BP;
                    end
                end
                PH_HEADER: begin
                    if (!ok) begin
                        o_res_valid = 1'b1;
                        o_res.kind = K_ERROR;
                    end else if (pos <= 6'd7) begin
                        pfx = i_state.prefix | ({28'd0, nib} << {pos[2:0], 2'b00});
                        mag = (pfx[2:0] == 3'd0) ? MAG8_CODE : {1'b0, pfx[2:0], 8'd0};
                        s.prefix = pfx;
                        if (pos == 6'd3 && (mag | {4'd0, pfx[15:8]}) != i_page) begin
                            s.pkts = 5'd0;
                            s.phase = PH_IGNORE;
                        end else if (pos == 6'd7) begin
                            s.phase = PH_IGNORE;
                            if (pfx[27:24] != i_stream) begin
                                s.pkts = 5'd0;
                            end else begin
                                if ({1'b0, pfx[19:16]} != i_state.exp_ci) begin
                                    o_res_valid = 1'b1;
                                    o_res.kind = K_RESET;
                                end
                                hdr_sync = 1'b1;
                                s.exp_ci = {1'b0, pfx[19:16] + 4'd1};
                                s.exp_pkt = 5'd1;
                                s.pkts = {pfx[29:28], pfx[22:20]};
                            end
                        end
                    end
                end
                PH_BP: begin
                    if (!ok || nib > 4'd13) begin
                        o_res_valid = 1'b1;
                        o_res.kind = K_ERROR;
                    end else begin
                        s.block_ptr = 6'({2'b00, nib} * 6'd3);
                        if (i_state.bytes_left != 11'd0) begin
                            s.phase = PH_COPY;
                        end else if (s.block_ptr >= MAX_BP) begin
                            s.phase = PH_IGNORE;
                        end else begin
                            s.phase = PH_SEEK;
                        end
                    end
                end
                PH_SEEK: begin
                    if ({1'b0, pos} >= {1'b0, i_state.block_ptr} + 7'd3) begin
                        if (!ok || nib != SEPARATOR) begin
                            o_res_valid = 1'b1;
                            o_res.kind = K_ERROR;
                        end else begin
                            s.reading_header = 1'b1;
                            s.bytes_left = 11'd4;
                            s.block_index = 11'd0;
                            s.header_bits = 16'd0;
                            s.header_bad = 1'b0;
                            s.phase = PH_COPY;
                        end
                    end
                end
                PH_COPY: begin
                    if (i_state.bytes_left == 11'd0) begin
                        s.phase = PH_IGNORE;
                    end else if (i_state.reading_header) begin
                        hb = i_state.header_bits |
                             ({12'd0, nib} << {i_state.block_index[1:0], 2'b00});
                        if (!ok) begin
                            s.header_bad = 1'b1;
                        end else begin
                            s.header_bits = hb;
                        end
                        s.block_index = i_state.block_index + 11'd1;
                        s.bytes_left = i_state.bytes_left - 11'd1;
                        if (s.bytes_left == 11'd0) begin
                            if (s.header_bad) begin
                                o_res_valid = 1'b1;
                                o_res.kind = K_ERROR;
                            end else begin
                                s.app_id = s.header_bits[4:0];
                                s.size = s.header_bits[15:5];
                                s.reading_header = 1'b0;
                                s.block_index = 11'd0;
                                if (s.size == 11'd0) begin
                                    s.phase = PH_SCAN;
                                    o_res_valid = 1'b1;
                                    o_res.kind = K_EMPTY;
                                    o_res.app_code = s.app_id;
                                    o_res.last_of_block = 1'b1;
                                end else begin
                                    s.bytes_left = s.size;
                                end
                            end
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.kind = K_DATA;
                        o_res.data_byte = i_item.byte_value;
                        o_res.block_offset = i_state.block_index;
                        o_res.app_code = i_state.app_id;
                        o_res.block_len = i_state.size;
                        o_res.last_of_block = (i_state.bytes_left == 11'd1);
                        s.block_index = i_state.block_index + 11'd1;
                        s.bytes_left = i_state.bytes_left - 11'd1;
                        if (s.bytes_left == 11'd0) begin
                            s.phase = PH_SCAN;
                        end
                    end
                end
                PH_SCAN: begin
                    if (!(ok && nib == FILLER)) begin
                        if (!ok || nib != SEPARATOR) begin
                            o_res_valid = 1'b1;
                            o_res.kind = K_ERROR;
                        end else begin
                            s.reading_header = 1'b1;
                            s.bytes_left = 11'd4;
                            s.block_index = 11'd0;
                            s.header_bits = 16'd0;
                            s.header_bad = 1'b0;
                            s.phase = PH_COPY;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // clear continuity and partial block on error or continuity reset
        if (o_res_valid && (o_res.kind == K_ERROR || o_res.kind == K_RESET)) begin
            s.exp_ci = NO_CI;
            s.exp_pkt = NO_PKT;
            s.pkts = 5'd0;
            s.block_index = 11'd0;
            s.bytes_left = 11'd0;
            s.reading_header = 1'b1;
            s.header_bits = 16'd0;
            s.header_bad = 1'b0;
            s.phase = PH_IGNORE;
        end
        // resync continuity from a matching page header
        if (hdr_sync) begin
            s.exp_ci = {1'b0, pfx[19:16] + 4'd1};
            s.exp_pkt = 5'd1;
            s.pkts = {pfx[29:28], pfx[22:20]};
        end
        o_state = s;
    end

endmodule

### hdl/teletext_pfc_block_demux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teletext_pfc_block_demux
// Teletext page function clear demultiplexer, one packet byte per transaction.
// Results are registered: a result appears in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output is not stalled, set by the single decode stage.
// Reset: synchronous, restores decode state, page, stream and output valid.
// ----------------------------------------------------------------------------
module teletext_pfc_block_demux (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tpbd_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output tpbd_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [11:0]    i_cfg_data
);
    import tpbd_pkg::*;

    t_state      r_state, n_state;
    logic [11:0] r_page;
    logic [3:0]  r_stream;
    logic        r_valid;
    t_out        r_out, n_out;
    logic        n_res_valid;
    logic        take;

    tpbd_step u_step (
        .i_state     (r_state),
        .i_item      (i_in),
        .i_page      (r_page),
        .i_stream    (r_stream),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_out)
    );

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{exp_ci: NO_CI, exp_pkt: NO_PKT, reading_header: 1'b1,
                         phase: PH_IGNORE, default: '0};
            r_page   <= 12'd256;
            r_stream <= 4'd0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PAGE:   r_page <= i_cfg_data;
                    CFG_STREAM: r_stream <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (take) begin
                r_state <= n_state;
                r_valid <= n_res_valid;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

### hdl/tpbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_checker
// Port-level checks for the PFC block demultiplexer.
// ----------------------------------------------------------------------------
module tpbd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input tpbd_pkg::t_out o_out
);
    import tpbd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_stall_pending: assert property (@(posedge i_clk)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.kind != K_DATA |->
            o_out.data_byte == 8'd0 && o_out.block_offset == 11'd0)
        else $error("non-data result carries payload");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.kind == K_ERROR || o_out.kind == K_RESET) |->
            o_out.app_code == 5'd0 && o_out.block_len == 11'd0 &&
            !o_out.last_of_block)
        else $error("error result carries block fields");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.kind == K_EMPTY |-> o_out.last_of_block &&
            o_out.block_len == 11'd0)
        else $error("empty block not marked last");

endmodule

bind teletext_pfc_block_demux tpbd_checker u_tpbd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
